// ----- sv/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

	// result commands
	typedef enum logic [1:0] {
		CMD_DRAW   = 2'd0,
		CMD_SCROLL = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// operations
	localparam logic OP_PRINT = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// control characters and glyphs
	localparam logic [7:0] CHAR_BS  = 8'd8;
	localparam logic [7:0] CHAR_TAB = 8'd9;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [6:0] GLYPH_SPACE    = 7'd32;
	localparam logic [6:0] GLYPH_QUESTION = 7'd63;

	// register indexes
	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_FG      = 2'd2;
	localparam logic [1:0] REG_BG      = 2'd3;

	// register reset values
	localparam logic [7:0]  RST_COLUMNS = 8'd80;
	localparam logic [6:0]  RST_ROWS    = 7'd25;
	localparam logic [23:0] RST_FG      = 24'hFFFFFF;
	localparam logic [23:0] RST_BG      = 24'h000000;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		cmd_t        command;
		logic [6:0]  glyph_code;
		logic [7:0]  cell_column;
		logic [6:0]  cell_row;
		logic [23:0] draw_foreground;
		logic [23:0] draw_background;
		logic        last;
	} out_item_t;

	// result of one cursor step
	typedef struct packed {
		logic [1:0] count;
		out_item_t  res0;
		out_item_t  res1;
		logic [7:0] next_column;
		logic [6:0] next_row;
	} step_t;

endpackage

`default_nettype wire

// ----- sv/tcc_step.sv -----
`default_nettype none

module tcc_step (
	input  var tcc_pkg::in_item_t item,
	input  var logic [7:0]        cursor_column,
	input  var logic [6:0]        cursor_row,
	input  var logic [7:0]        columns,
	input  var logic [6:0]        rows,
	input  var logic [23:0]       fg,
	input  var logic [23:0]       bg,
	output tcc_pkg::step_t        step
);
	import tcc_pkg::*;

	logic [8:0] col;
	logic [7:0] row;
	logic       draw;
	logic       scroll;
	logic [6:0] glyph;
	logic [7:0] draw_col;
	out_item_t  draw_res;
	out_item_t  scroll_res;

	// cursor movement and draw decision
	always_comb begin
		col      = {1'b0, cursor_column};
		row      = {1'b0, cursor_row};
		draw     = 1'b0;
		glyph    = item.char_code[6:0];
		draw_col = cursor_column;
		unique case (item.char_code)
			CHAR_LF: begin
				col = 9'd0;
				row = row + 8'd1;
			end
			CHAR_CR: begin
				col = 9'd0;
			end
			CHAR_TAB: begin
				col = {({1'b0, cursor_column[7:2]} + 7'd1), 2'b00};
			end
			CHAR_BS: begin
				if (cursor_column != 8'd0) begin
					col      = col - 9'd1;
					draw     = 1'b1;
					glyph    = GLYPH_SPACE;
					draw_col = cursor_column - 8'd1;
				end
			end
			default: begin
				draw = 1'b1;
				if (item.char_code[7]) begin
					glyph = GLYPH_QUESTION;
				end
				col = col + 9'd1;
			end
		endcase
		// column overflow wraps to the next row
		if (col >= {1'b0, columns}) begin
			col = 9'd0;
			row = row + 8'd1;
		end
		// row overflow scrolls and holds on the last row
		scroll = (row >= {1'b0, rows});
		if (scroll) begin
			row = {1'b0, rows - 7'd1};
		end
	end

	// result assembly
	always_comb begin
		draw_res                 = '0;
		draw_res.command         = CMD_DRAW;
		draw_res.glyph_code      = glyph;
		draw_res.cell_column     = draw_col;
		draw_res.cell_row        = cursor_row;
		draw_res.draw_foreground = fg;
		draw_res.draw_background = bg;
		draw_res.last            = !scroll;

		scroll_res                 = '0;
		scroll_res.command         = CMD_SCROLL;
		scroll_res.draw_background = bg;
		scroll_res.last            = 1'b1;

		step = '0;
		if (item.operation == OP_CLEAR) begin
			step.count                = 2'd1;
			step.res0.command         = CMD_CLEAR;
			step.res0.draw_background = bg;
			step.res0.last            = 1'b1;
			step.next_column          = 8'd0;
			step.next_row             = 7'd0;
		end else begin
			step.next_column = col[7:0];
			step.next_row    = row[6:0];
			step.res1        = scroll_res;
			if (draw) begin
				step.res0  = draw_res;
				step.count = scroll ? 2'd2 : 2'd1;
			end else begin
				step.res0  = scroll_res;
				step.count = scroll ? 2'd1 : 2'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/text_console_cursor_control.sv -----
// channel  | direction | handshake        | payload
// in       | input     | in_valid/ready   | in_data   (operation, char_code)
// out      | output    | out_valid/ready  | out_data  (command .. last)
// cfg      | input     | APB write/read   | paddr, pwdata, prdata
//
// an item is registered on transfer, then its cursor step is worked out
// combinationally and its results are loaded into a two-entry result register
// one item per cycle when each gives at most one result and the output is ready;
// an item that draws and scrolls holds the next one back until its scroll result is taken
// reset clears the cursor, the registers to their defaults and all valid flags
// a stalled output holds the pending results; input stalls behind them

`default_nettype none

module text_console_cursor_control #(
	parameter int MAX_COLUMNS   = 255,
	parameter int MAX_TEXT_ROWS = 127
) (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              in_valid,
	output logic                  in_ready,
	input  var tcc_pkg::in_item_t in_data,
	output logic                  out_valid,
	input  var logic              out_ready,
	output tcc_pkg::out_item_t    out_data,
	input  var logic              psel,
	input  var logic              penable,
	input  var logic              pwrite,
	input  var logic [3:0]        paddr,
	input  var logic [31:0]       pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import tcc_pkg::*;

	localparam logic [7:0] MaxCols = 8'(MAX_COLUMNS);
	localparam logic [6:0] MaxRows = 7'(MAX_TEXT_ROWS);

	logic [7:0]  columns_q;
	logic [6:0]  rows_q;
	logic [23:0] fg_q;
	logic [23:0] bg_q;
	logic [7:0]  columns;
	logic [6:0]  rows;
	logic [1:0]  reg_idx;

	logic        valid_s1;
	in_item_t    item_s1;
	logic [7:0]  cursor_column_q;
	logic [6:0]  cursor_row_q;
	step_t       step;

	out_item_t   slot0_q;
	out_item_t   slot1_q;
	logic [1:0]  count_q;
	logic        pop;
	logic        advance;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= RST_COLUMNS;
			rows_q    <= RST_ROWS;
			fg_q      <= RST_FG;
			bg_q      <= RST_BG;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_COLUMNS: columns_q <= pwdata[7:0];
				REG_ROWS:    rows_q    <= pwdata[6:0];
				REG_FG:      fg_q      <= pwdata[23:0];
				REG_BG:      bg_q      <= pwdata[23:0];
				default:     columns_q <= columns_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_COLUMNS: prdata = {24'd0, columns_q};
			REG_ROWS:    prdata = {25'd0, rows_q};
			REG_FG:      prdata = {8'd0, fg_q};
			REG_BG:      prdata = {8'd0, bg_q};
			default:     prdata = 32'd0;
		endcase
	end

	// geometry limited to at least one cell and the build maximum
	always_comb begin
		if (columns_q == 8'd0) begin
			columns = 8'd1;
		end else if (columns_q > MaxCols) begin
			columns = MaxCols;
		end else begin
			columns = columns_q;
		end
		if (rows_q == 7'd0) begin
			rows = 7'd1;
		end else if (rows_q > MaxRows) begin
			rows = MaxRows;
		end else begin
			rows = rows_q;
		end
	end

	// cursor step for the registered item
	tcc_step u_step (
		.item          (item_s1),
		.cursor_column (cursor_column_q),
		.cursor_row    (cursor_row_q),
		.columns       (columns),
		.rows          (rows),
		.fg            (fg_q),
		.bg            (bg_q),
		.step          (step)
	);

	// handshake control
	assign out_valid = (count_q != 2'd0);
	assign out_data  = slot0_q;
	assign pop       = out_valid && out_ready;
	assign advance   = valid_s1 && ((step.count == 2'd0) || (count_q == 2'd0) ||
		((count_q == 2'd1) && pop));
	assign in_ready  = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= 8'd0;
			cursor_row_q    <= 7'd0;
		end else if (advance) begin
			cursor_column_q <= step.next_column;
			cursor_row_q    <= step.next_row;
		end
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (advance && (step.count != 2'd0)) begin
			count_q <= step.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// result register contents
	always_ff @(posedge clk) begin
		if (advance && (step.count != 2'd0)) begin
			slot0_q <= step.res0;
			slot1_q <= step.res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

`default_nettype wire
